>>> src/sell_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sell_pkg
// Shared widths, constants, codes and types of the Sellmeier index core.
// ----------------------------------------------------------------------------
package sell_pkg;

   // Wavelength in Q12.12 nm and its square in micrometres squared (Q5.32).
   localparam int W_WIDTH         = 24;
   localparam int SQ_WIDTH        = 2 * W_WIDTH;
   localparam int S_WIDTH         = 37;
   localparam int SCALE_NUM_WIDTH = SQ_WIDTH + 3;

   // s = floor((4*W*W + 7812) / 15625) equals round(W*W*256 / 10^6). The
   // quotient is the numerator times ceil(2^65 / 15625) shifted right by 65,
   // which is exact for every numerator below 2^51.
   localparam int unsigned SCALE_BIAS        = 7812;
   localparam int          SCALE_SHIFT       = 65;
   localparam int          SCALE_RECIP_WIDTH = 52;
   localparam logic [SCALE_RECIP_WIDTH-1:0] SCALE_RECIP = 52'd2361183241434823;
   localparam logic [31:0]                  SCALE_RECIP_LO = SCALE_RECIP[31:0];
   localparam logic [SCALE_RECIP_WIDTH-33:0] SCALE_RECIP_HI =
      SCALE_RECIP[SCALE_RECIP_WIDTH-1:32];

   localparam int K_WIDTH        = 32;
   localparam int L_WIDTH        = 40;
   localparam int CSR_DATA_WIDTH = 40;
   localparam int CSR_IDX_WIDTH  = 3;
   localparam int DIFF_WIDTH     = 42;
   localparam int ABS_D_WIDTH    = 40;
   localparam int PROD_WIDTH     = 69;
   localparam int Q_WIDTH        = 40;
   localparam int TERM_WIDTH     = 42;
   localparam int RAD_WIDTH      = 44;
   localparam int RAD_INT_BITS   = 36;
   localparam int ROOT_WIDTH     = 32;
   localparam int SQ_REM_WIDTH   = 34;
   localparam int IDX_WIDTH      = 32;

   localparam logic [IDX_WIDTH-1:0] IDX_MAX           = '1;
   localparam logic [IDX_WIDTH-1:0] FIXED_INDEX_RESET = 32'h1000_0000;
   localparam logic [RAD_WIDTH-1:0] ONE_Q428          = 44'h000_1000_0000;

   typedef enum logic [1:0] {
      STATUS_OK           = 2'd0,
      STATUS_ZERO_DEN     = 2'd1,
      STATUS_NEG_RADICAND = 2'd2,
      STATUS_OVERFLOW     = 2'd3
   } status_type;

   typedef enum logic [CSR_IDX_WIDTH-1:0] {
      CSR_K_ONE       = 3'd0,
      CSR_L_ONE       = 3'd1,
      CSR_K_TWO       = 3'd2,
      CSR_L_TWO       = 3'd3,
      CSR_K_THREE     = 3'd4,
      CSR_L_THREE     = 3'd5,
      CSR_GLASS_MODE  = 3'd6,
      CSR_FIXED_INDEX = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [TERM_WIDTH-1:0] value;
      status_type            status;
   } term_result_type;

endpackage

>>> src/sell_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sell_req_if / sell_rsp_if
// Valid/ready channels for wavelength requests and index results.
// ----------------------------------------------------------------------------
interface sell_req_if;
   logic                         valid;
   logic                         ready;
   logic [sell_pkg::W_WIDTH-1:0] wavelength_nm;

   modport source (output valid, output wavelength_nm, input ready);
   modport sink (input valid, input wavelength_nm, output ready);
endinterface

interface sell_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [sell_pkg::IDX_WIDTH-1:0] refractive_index;
   sell_pkg::status_type           status;

   modport source (output valid, output refractive_index, output status, input ready);
   modport sink (input valid, input refractive_index, input status, output ready);
endinterface

>>> src/sell_scale.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sell_scale
// Squares the wavelength and divides by a constant through a reciprocal product.
// ----------------------------------------------------------------------------
module sell_scale (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         en,
   input  logic                         in_valid,
   input  logic [sell_pkg::W_WIDTH-1:0] wavelength_nm,
   output logic                         out_valid,
   output logic [sell_pkg::S_WIDTH-1:0] s_um
);
   localparam int NumW  = sell_pkg::SCALE_NUM_WIDTH;
   localparam int SqW   = sell_pkg::SQ_WIDTH;
   localparam int SW    = sell_pkg::S_WIDTH;
   localparam int Shift = sell_pkg::SCALE_SHIFT;
   localparam int XHiW  = NumW - 32;
   localparam int MHiW  = sell_pkg::SCALE_RECIP_WIDTH - 32;
   localparam int LlW   = 64;
   localparam int LhW   = 32 + MHiW;
   localparam int HlW   = XHiW + 32;
   localparam int HhW   = XHiW + MHiW;
   localparam int MidW  = LhW + 1;
   localparam int CatW  = LlW + HhW;

   logic [SqW-1:0]  sq_in;
   logic [SqW-1:0]  sq_ff;
   logic [NumW-1:0] x_in;
   logic [NumW-1:0] x_ff;
   logic [LlW-1:0]  pp_ll_ff;
   logic [LhW-1:0]  pp_lh_ff;
   logic [HlW-1:0]  pp_hl_ff;
   logic [HhW-1:0]  pp_hh_ff;
   logic [CatW-1:0] cat_ff;
   logic [MidW-1:0] mid_ff;
   logic [CatW-1:0] total;
   logic [SW-1:0]   s_ff;
   logic            v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;

   assign sq_in = SqW'(wavelength_nm) * SqW'(wavelength_nm);
   assign x_in  = {1'b0, sq_ff, 2'b00} + NumW'(sell_pkg::SCALE_BIAS);
   assign total = cat_ff + CatW'({mid_ff, 32'b0});

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
   end

   // The numerator and the reciprocal are split at bit 32 into four partial
   // products; the low and high products sit side by side without overlap.
   always_ff @(posedge clock) begin
      if (en) begin
         sq_ff    <= sq_in;
         x_ff     <= x_in;
         pp_ll_ff <= LlW'(x_ff[31:0]) * LlW'(sell_pkg::SCALE_RECIP_LO);
         pp_lh_ff <= LhW'(x_ff[31:0]) * LhW'(sell_pkg::SCALE_RECIP_HI);
         pp_hl_ff <= HlW'(x_ff[NumW-1:32]) * HlW'(sell_pkg::SCALE_RECIP_LO);
         pp_hh_ff <= HhW'(x_ff[NumW-1:32]) * HhW'(sell_pkg::SCALE_RECIP_HI);
         cat_ff   <= {pp_hh_ff, pp_ll_ff};
         mid_ff   <= MidW'(pp_lh_ff) + MidW'(pp_hl_ff);
         s_ff     <= total[Shift+SW-1:Shift];
      end
   end

   assign out_valid = v5_ff;
   assign s_um      = s_ff;

endmodule

>>> src/sell_term.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sell_term
// One Sellmeier term K*s/(s-L), rounded, through a pipelined divider.
// ----------------------------------------------------------------------------
module sell_term (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             en,
   input  logic                             in_valid,
   input  logic [sell_pkg::S_WIDTH-1:0]     s_um,
   input  logic [sell_pkg::K_WIDTH-1:0]     coef_k,
   input  logic [sell_pkg::L_WIDTH-1:0]     coef_l,
   output logic                             out_valid,
   output sell_pkg::term_result_type        result
);
   localparam int Steps = sell_pkg::Q_WIDTH;
   localparam int SW    = sell_pkg::S_WIDTH;
   localparam int KW    = sell_pkg::K_WIDTH;
   localparam int LW    = sell_pkg::L_WIDTH;
   localparam int DW    = sell_pkg::DIFF_WIDTH;
   localparam int AW    = sell_pkg::ABS_D_WIDTH;
   localparam int PW    = sell_pkg::PROD_WIDTH;
   localparam int TW    = sell_pkg::TERM_WIDTH;
   localparam int HiW   = SW - 32;

   // Stage one: denominator and magnitude of K.
   logic [DW-1:0] d_in, d_ff;
   logic [KW-1:0] ak_in, ak_ff;
   logic          kneg_ff;
   logic [SW-1:0] s_ff;
   logic          p0_valid_ff;

   // Stage two: magnitude of the denominator and partial products.
   logic [AW-1:0]     ad_in, ad1_ff;
   logic              dz1_ff, neg1_ff;
   logic [63:0]       plo_ff;
   logic [KW+HiW-1:0] phi_ff;
   logic              p1_valid_ff;

   // Stage three: rounded numerator.
   logic [PW-1:0] n_in, n_ff;
   logic [AW-1:0] ad2_ff;
   logic          dz2_ff, neg2_ff;
   logic          p2_valid_ff;

   logic [AW-1:0]    rem_ff  [0:Steps-1];
   logic [AW-1:0]    ad_ff   [0:Steps-1];
   logic [Steps-1:0] low_ff  [0:Steps];
   logic             neg_ff  [0:Steps];
   logic             dz_ff   [0:Steps];
   logic             ovf_ff  [0:Steps];
   logic             valid_ff[0:Steps];
   logic [AW-1:0]    n_top;

   assign d_in  = {{(DW-SW){1'b0}}, s_um} - {{(DW-LW){coef_l[LW-1]}}, coef_l};
   assign ak_in = coef_k[KW-1] ? (~coef_k + KW'(1)) : coef_k;
   assign ad_in = d_ff[DW-1] ? AW'(~d_ff + DW'(1)) : d_ff[AW-1:0];
   assign n_in  = PW'(plo_ff) + {phi_ff, 32'b0} + PW'(ad1_ff[AW-1:1]);
   assign n_top = AW'(n_ff[PW-1:Steps]);

   always_ff @(posedge clock) begin
      if (reset) begin
         p0_valid_ff <= 1'b0;
         p1_valid_ff <= 1'b0;
         p2_valid_ff <= 1'b0;
         valid_ff[0] <= 1'b0;
      end else if (en) begin
         p0_valid_ff <= in_valid;
         p1_valid_ff <= p0_valid_ff;
         p2_valid_ff <= p1_valid_ff;
         valid_ff[0] <= p2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d_ff    <= d_in;
         ak_ff   <= ak_in;
         kneg_ff <= coef_k[KW-1];
         s_ff    <= s_um;

         ad1_ff  <= ad_in;
         dz1_ff  <= (d_ff == '0);
         neg1_ff <= kneg_ff ^ d_ff[DW-1];
         plo_ff  <= 64'(ak_ff) * 64'(s_ff[31:0]);
         phi_ff  <= (KW+HiW)'(ak_ff) * (KW+HiW)'(s_ff[SW-1:32]);

         n_ff    <= n_in;
         ad2_ff  <= ad1_ff;
         dz2_ff  <= dz1_ff;
         neg2_ff <= neg1_ff;

         // A quotient of 2^40 or more shows as a top part not below the divisor.
         rem_ff[0] <= n_top;
         low_ff[0] <= n_ff[Steps-1:0];
         ad_ff[0]  <= ad2_ff;
         neg_ff[0] <= neg2_ff;
         dz_ff[0]  <= dz2_ff;
         ovf_ff[0] <= n_top >= ad2_ff;
      end
   end

   for (genvar g = 1; g <= Steps; g++) begin : g_step
      logic [AW:0] trial;
      logic        take;

      assign trial = {rem_ff[g-1], low_ff[g-1][Steps-1]};
      assign take  = trial >= {1'b0, ad_ff[g-1]};

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[g] <= 1'b0;
         end else if (en) begin
            valid_ff[g] <= valid_ff[g-1];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            low_ff[g] <= {low_ff[g-1][Steps-2:0], take};
            neg_ff[g] <= neg_ff[g-1];
            dz_ff[g]  <= dz_ff[g-1];
            ovf_ff[g] <= ovf_ff[g-1];
         end
      end

      if (g < Steps) begin : g_rem
         logic [AW:0] diff;

         assign diff = trial - {1'b0, ad_ff[g-1]};

         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[g] <= take ? diff[AW-1:0] : trial[AW-1:0];
               ad_ff[g]  <= ad_ff[g-1];
            end
         end
      end
   end

   always_comb begin
      result.value = neg_ff[Steps] ? (~{{(TW-Steps){1'b0}}, low_ff[Steps]} + TW'(1))
                                   : {{(TW-Steps){1'b0}}, low_ff[Steps]};
      if (dz_ff[Steps]) begin
         result.status = sell_pkg::STATUS_ZERO_DEN;
      end else if (ovf_ff[Steps]) begin
         result.status = sell_pkg::STATUS_OVERFLOW;
      end else begin
         result.status = sell_pkg::STATUS_OK;
      end
   end

   assign out_valid = valid_ff[Steps];

endmodule

>>> src/sell_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sell_sqrt
// Sums the terms, checks the radicand and takes a pipelined rounded root.
// ----------------------------------------------------------------------------
module sell_sqrt (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           en,
   input  logic                           in_valid,
   input  sell_pkg::term_result_type      term_a,
   input  sell_pkg::term_result_type      term_b,
   input  sell_pkg::term_result_type      term_c,
   output logic                           out_valid,
   output logic [sell_pkg::IDX_WIDTH-1:0] index_out,
   output sell_pkg::status_type           status_out
);
   localparam int Steps = sell_pkg::ROOT_WIDTH;
   localparam int RW    = sell_pkg::RAD_WIDTH;
   localparam int TW    = sell_pkg::TERM_WIDTH;
   localparam int RI    = sell_pkg::RAD_INT_BITS;
   localparam int MW    = sell_pkg::SQ_REM_WIDTH;
   localparam int NW    = 2 * Steps;
   localparam int XW    = MW + 2;

   logic [RW-1:0]        a_ff, b_ff, rad_ff;
   sell_pkg::status_type worst_in, worst0_ff, worst1_ff;
   logic                 r0_valid_ff, r1_valid_ff;

   logic [MW-1:0]        rem_ff   [0:Steps];
   logic [Steps-1:0]     root_ff  [0:Steps];
   logic [NW-1:0]        nrest_ff [0:Steps-1];
   sell_pkg::status_type pre_ff   [0:Steps];
   logic                 valid_ff [0:Steps];
   sell_pkg::status_type pre_in;
   logic                 round_up;
   logic [Steps:0]       idx;

   // A zero denominator outranks an overflowing term.
   always_comb begin
      if (term_a.status == sell_pkg::STATUS_ZERO_DEN ||
          term_b.status == sell_pkg::STATUS_ZERO_DEN ||
          term_c.status == sell_pkg::STATUS_ZERO_DEN) begin
         worst_in = sell_pkg::STATUS_ZERO_DEN;
      end else if (term_a.status == sell_pkg::STATUS_OVERFLOW ||
                   term_b.status == sell_pkg::STATUS_OVERFLOW ||
                   term_c.status == sell_pkg::STATUS_OVERFLOW) begin
         worst_in = sell_pkg::STATUS_OVERFLOW;
      end else begin
         worst_in = sell_pkg::STATUS_OK;
      end
   end

   always_comb begin
      if (worst1_ff != sell_pkg::STATUS_OK) begin
         pre_in = worst1_ff;
      end else if (rad_ff[RW-1]) begin
         pre_in = sell_pkg::STATUS_NEG_RADICAND;
      end else if (rad_ff[RW-2:RI] != '0) begin
         pre_in = sell_pkg::STATUS_OVERFLOW;
      end else begin
         pre_in = sell_pkg::STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         r0_valid_ff <= 1'b0;
         r1_valid_ff <= 1'b0;
         valid_ff[0] <= 1'b0;
      end else if (en) begin
         r0_valid_ff <= in_valid;
         r1_valid_ff <= r0_valid_ff;
         valid_ff[0] <= r1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_ff      <= {{(RW-TW){term_a.value[TW-1]}}, term_a.value}
                    + {{(RW-TW){term_b.value[TW-1]}}, term_b.value};
         b_ff      <= {{(RW-TW){term_c.value[TW-1]}}, term_c.value} + sell_pkg::ONE_Q428;
         worst0_ff <= worst_in;

         rad_ff    <= a_ff + b_ff;
         worst1_ff <= worst0_ff;

         // The root operand is the radicand times 2^28.
         rem_ff[0]   <= '0;
         root_ff[0]  <= '0;
         nrest_ff[0] <= {rad_ff[RI-1:0], {(NW-RI){1'b0}}};
         pre_ff[0]   <= pre_in;
      end
   end

   for (genvar g = 1; g <= Steps; g++) begin : g_step
      logic [XW-1:0] trial;
      logic [XW-1:0] test;
      logic [XW-1:0] diff;
      logic          take;

      assign trial = {rem_ff[g-1], nrest_ff[g-1][NW-1:NW-2]};
      assign test  = {{(XW-Steps-2){1'b0}}, root_ff[g-1], 2'b01};
      assign diff  = trial - test;
      assign take  = trial >= test;

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[g] <= 1'b0;
         end else if (en) begin
            valid_ff[g] <= valid_ff[g-1];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[g]  <= take ? diff[MW-1:0] : trial[MW-1:0];
            root_ff[g] <= {root_ff[g-1][Steps-2:0], take};
            pre_ff[g]  <= pre_ff[g-1];
         end
      end

      if (g < Steps) begin : g_shift
         always_ff @(posedge clock) begin
            if (en) begin
               nrest_ff[g] <= {nrest_ff[g-1][NW-3:0], 2'b00};
            end
         end
      end
   end

   // A remainder above the root rounds the index up.
   assign round_up = rem_ff[Steps] > {{(MW-Steps){1'b0}}, root_ff[Steps]};
   assign idx      = {1'b0, root_ff[Steps]} + (Steps+1)'(round_up);

   always_comb begin
      if (pre_ff[Steps] == sell_pkg::STATUS_NEG_RADICAND) begin
         index_out  = '0;
         status_out = pre_ff[Steps];
      end else if (pre_ff[Steps] != sell_pkg::STATUS_OK) begin
         index_out  = sell_pkg::IDX_MAX;
         status_out = pre_ff[Steps];
      end else if (idx[Steps]) begin
         index_out  = sell_pkg::IDX_MAX;
         status_out = sell_pkg::STATUS_OVERFLOW;
      end else begin
         index_out  = idx[Steps-1:0];
         status_out = sell_pkg::STATUS_OK;
      end
   end

   assign out_valid = valid_ff[Steps];

endmodule

>>> src/sellmeier_refractive_index_core.sv
`timescale 1ns / 1ps
// Throughput: one request per cycle while the skid register is empty; the 5-stage
// reciprocal scaling, the 40-stage term dividers and the 32-stage square root each
// take a new request every cycle unless the pipeline is stalled.
// Reset (synchronous, active high) empties the pipeline and output buffer and
// loads the register defaults: coefficients zero, glass mode on, fixed index 1.0.
// ----------------------------------------------------------------------------
// sellmeier_refractive_index_core
// Three-term Sellmeier refractive index in fixed point, fully pipelined.
// ----------------------------------------------------------------------------
module sellmeier_refractive_index_core (
   input  logic                                clock,
   input  logic                                reset,
   sell_req_if.sink                            req_bus,
   sell_rsp_if.source                          rsp_bus,
   input  logic                                csr_write_en,
   input  logic [sell_pkg::CSR_IDX_WIDTH-1:0]  csr_index,
   input  logic [sell_pkg::CSR_DATA_WIDTH-1:0] csr_write_data
);
   localparam int KW = sell_pkg::K_WIDTH;
   localparam int LW = sell_pkg::L_WIDTH;
   localparam int IW = sell_pkg::IDX_WIDTH;

   // Configuration registers; every stage reads them directly. The user must change
   // them only while the pipeline is empty: the block itself does not enforce it.
   logic [KW-1:0] coef_k_ff [0:2];
   logic [LW-1:0] coef_l_ff [0:2];
   logic          glass_ff;
   logic [IW-1:0] fixed_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            coef_k_ff[i] <= '0;
            coef_l_ff[i] <= '0;
         end
         glass_ff <= 1'b1;
         fixed_ff <= sell_pkg::FIXED_INDEX_RESET;
      end else if (csr_write_en) begin
         case (sell_pkg::csr_index_type'(csr_index))
            sell_pkg::CSR_K_ONE:       coef_k_ff[0] <= csr_write_data[KW-1:0];
            sell_pkg::CSR_L_ONE:       coef_l_ff[0] <= csr_write_data[LW-1:0];
            sell_pkg::CSR_K_TWO:       coef_k_ff[1] <= csr_write_data[KW-1:0];
            sell_pkg::CSR_L_TWO:       coef_l_ff[1] <= csr_write_data[LW-1:0];
            sell_pkg::CSR_K_THREE:     coef_k_ff[2] <= csr_write_data[KW-1:0];
            sell_pkg::CSR_L_THREE:     coef_l_ff[2] <= csr_write_data[LW-1:0];
            sell_pkg::CSR_GLASS_MODE:  glass_ff     <= csr_write_data[0];
            sell_pkg::CSR_FIXED_INDEX: fixed_ff     <= csr_write_data[IW-1:0];
            default: ;
         endcase
      end
   end

   // The whole pipeline advances together. It stops only when the skid
   // register is occupied, so a waiting result never blocks new requests
   // until two results are queued at the output.
   logic skid_valid_ff;
   logic en;

   assign en            = !skid_valid_ff;
   assign req_bus.ready = en;

   // Wavelength to micrometres squared.
   logic                         s_valid;
   logic [sell_pkg::S_WIDTH-1:0] s_um;

   sell_scale u_scale (
      .clock         (clock),
      .reset         (reset),
      .en            (en),
      .in_valid      (req_bus.valid),
      .wavelength_nm (req_bus.wavelength_nm),
      .out_valid     (s_valid),
      .s_um          (s_um)
   );

   // Three oscillator terms run as parallel lanes of equal depth.
   logic                      term_valid [0:2];
   sell_pkg::term_result_type term_res   [0:2];

   for (genvar g = 0; g < 3; g++) begin : g_lane
      sell_term u_term (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (s_valid),
         .s_um      (s_um),
         .coef_k    (coef_k_ff[g]),
         .coef_l    (coef_l_ff[g]),
         .out_valid (term_valid[g]),
         .result    (term_res[g])
      );
   end

   // Sum, range checks and rounded square root.
   logic                 root_valid;
   logic [IW-1:0]        root_index;
   sell_pkg::status_type root_status;

   sell_sqrt u_sqrt (
      .clock      (clock),
      .reset      (reset),
      .en         (en),
      .in_valid   (term_valid[0] & term_valid[1] & term_valid[2]),
      .term_a     (term_res[0]),
      .term_b     (term_res[1]),
      .term_c     (term_res[2]),
      .out_valid  (root_valid),
      .index_out  (root_index),
      .status_out (root_status)
   );

   // With glass mode off the fixed index replaces the computed one.
   logic [IW-1:0]        new_index;
   sell_pkg::status_type new_status;

   assign new_index  = glass_ff ? root_index : fixed_ff;
   assign new_status = glass_ff ? root_status : sell_pkg::STATUS_OK;

   // Output register plus one skid register.
   logic                 out_valid_ff;
   logic [IW-1:0]        out_index_ff, skid_index_ff;
   sell_pkg::status_type out_status_ff, skid_status_ff;
   logic                 push;
   logic                 pop;

   assign push = en && root_valid;
   assign pop  = out_valid_ff && rsp_bus.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (pop) begin
            out_index_ff  <= skid_index_ff;
            out_status_ff <= skid_status_ff;
            skid_valid_ff <= 1'b0;
         end
      end else if (push) begin
         if (!out_valid_ff || pop) begin
            out_index_ff  <= new_index;
            out_status_ff <= new_status;
            out_valid_ff  <= 1'b1;
         end else begin
            skid_index_ff  <= new_index;
            skid_status_ff <= new_status;
            skid_valid_ff  <= 1'b1;
         end
      end else if (pop) begin
         out_valid_ff <= 1'b0;
      end
   end

   assign rsp_bus.valid            = out_valid_ff;
   assign rsp_bus.refractive_index = out_index_ff;
   assign rsp_bus.status           = out_status_ff;

endmodule
